// ----- rtl/core/upd_pkg.sv -----
// Package with the request, response and classified item types of the URL percent decoder.
package upd_pkg;

   localparam logic [7:0] CHAR_PLUS    = 8'h2B;
   localparam logic [7:0] CHAR_PERCENT = 8'h25;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_NINE    = 8'h39;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_F = 8'h46;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_F = 8'h66;
   localparam logic [7:0] HEX_TEN      = 8'd10;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       has_byte;
      logic       end_of_string;
      logic       aborted;
   } rsp_type;

   typedef struct packed {
      logic       ok;
      logic [3:0] value;
   } hex_type;

   // One request after classification, as it travels through the queue.
   typedef struct packed {
      logic [7:0] raw_byte;
      logic       last;
      logic       is_percent;
      logic       is_plus;
      hex_type    hex;
   } cls_type;

   function automatic hex_type hex_digit(input logic [7:0] c);
      hex_type    h;
      logic [7:0] diff;
      h    = '0;
      diff = '0;
      if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
         diff = c - CHAR_ZERO;
         h.ok = 1'b1;
      end else if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_F) begin
         diff = c - CHAR_UPPER_A + HEX_TEN;
         h.ok = 1'b1;
      end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_F) begin
         diff = c - CHAR_LOWER_A + HEX_TEN;
         h.ok = 1'b1;
      end
      h.value = diff[3:0];
      return h;
   endfunction

endpackage

// ----- rtl/core/upd_front.sv -----
// Front end: accepts requests, classifies each byte and pushes it into the queue.
module upd_front (
   input  logic            req_valid,
   output logic            req_stall,
   input  upd_pkg::req_type req_payload,
   input  logic            queue_full,
   output logic            push,
   output upd_pkg::cls_type item
);
   import upd_pkg::*;

   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;

   always_comb begin
      item            = '0;
      item.raw_byte   = req_payload.in_byte;
      item.last       = req_payload.in_last;
      item.is_percent = (req_payload.in_byte == CHAR_PERCENT);
      item.is_plus    = (req_payload.in_byte == CHAR_PLUS);
      item.hex        = hex_digit(req_payload.in_byte);
   end

endmodule

// ----- rtl/core/upd_queue.sv -----
// Short queue of classified requests between the front end and the back end.
module upd_queue #(
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  upd_pkg::cls_type push_item,
   output logic             full,
   output logic             not_empty,
   input  logic             pop,
   output upd_pkg::cls_type head
);
   import upd_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   cls_type         entry_ff [DEPTH];
   logic [AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;

   assign full      = (count_ff == CW'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + AW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ----- rtl/core/upd_back.sv -----
// Back end: escape state machine and registered response output.
module upd_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             item_valid,
   input  upd_pkg::cls_type item,
   output logic             pop,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output upd_pkg::rsp_type rsp_payload
);
   import upd_pkg::*;

   typedef enum logic [3:0] {
      PH_NORMAL = 4'b0001,
      PH_HIGH   = 4'b0010,
      PH_LOW    = 4'b0100,
      PH_DROP   = 4'b1000
   } phase_type;

   phase_type  phase_ff, phase_in;
   logic [3:0] nibble_ff, nibble_in;
   logic       abort_ff, abort_in;
   logic       out_valid_ff, out_valid_in;
   rsp_type    out_ff;
   rsp_type    result;
   logic       emit;
   logic       give;
   logic [7:0] give_byte;
   logic       stop;
   logic       stop_abort;

   // The output register frees up when it is empty or being taken this cycle.
   assign pop         = item_valid && (!out_valid_ff || !rsp_stall);
   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_ff;

   always_comb begin
      phase_in   = phase_ff;
      nibble_in  = nibble_ff;
      abort_in   = abort_ff;
      emit       = 1'b0;
      result     = '0;
      give       = 1'b0;
      give_byte  = '0;
      stop       = 1'b0;
      stop_abort = 1'b0;

      unique case (phase_ff)
         PH_NORMAL: begin
            if (item.is_percent) begin
               if (item.last) begin
                  stop       = 1'b1;
                  stop_abort = 1'b1;
               end else begin
                  phase_in = PH_HIGH;
               end
            end else begin
               give      = 1'b1;
               give_byte = item.is_plus ? CHAR_SPACE : item.raw_byte;
            end
         end
         PH_HIGH: begin
            if (!item.hex.ok || item.last) begin
               stop       = 1'b1;
               stop_abort = 1'b1;
            end else begin
               nibble_in = item.hex.value;
               phase_in  = PH_LOW;
            end
         end
         PH_LOW: begin
            if (!item.hex.ok) begin
               stop       = 1'b1;
               stop_abort = 1'b1;
            end else begin
               give      = 1'b1;
               give_byte = {nibble_ff, item.hex.value};
            end
         end
         PH_DROP: begin
            if (item.last) begin
               emit                 = 1'b1;
               result.end_of_string = 1'b1;
               result.aborted       = abort_ff;
               phase_in             = PH_NORMAL;
               nibble_in            = '0;
               abort_in             = 1'b0;
            end
         end
         default: begin
            phase_in = PH_NORMAL;
         end
      endcase

      // A zero byte, raw or decoded, ends the string quietly.
      if (give && give_byte == '0) begin
         stop       = 1'b1;
         stop_abort = 1'b0;
      end else if (give) begin
         emit                 = 1'b1;
         result.out_byte      = give_byte;
         result.has_byte      = 1'b1;
         result.end_of_string = item.last;
         phase_in             = PH_NORMAL;
         nibble_in            = '0;
         abort_in             = 1'b0;
      end

      if (stop) begin
         nibble_in = '0;
         if (item.last) begin
            emit                 = 1'b1;
            result.end_of_string = 1'b1;
            result.aborted       = stop_abort;
            phase_in             = PH_NORMAL;
            abort_in             = 1'b0;
         end else begin
            phase_in = PH_DROP;
            abort_in = stop_abort;
         end
      end
   end

   always_comb begin
      if (pop) begin
         out_valid_in = emit;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_NORMAL;
         nibble_ff    <= '0;
         abort_ff     <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (pop) begin
            phase_ff  <= phase_in;
            nibble_ff <= nibble_in;
            abort_ff  <= abort_in;
         end
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop && emit) begin
         out_ff <= result;
      end
   end

endmodule

// ----- rtl/core/url_percent_decoder.sv -----
// Top level of the URL percent decoder: front end, request queue and back end.
//
// Requests carry one encoded byte and a last mark; the req_ channel accepts
// one when req_valid is high and req_stall is low. Responses leave on the
// rsp_ channel under the same rule, with rsp_stall driven by the receiver.
// Each request yields zero or one response: a decoded byte, an end marker, or
// both on the last byte of a string. Bytes of an escape before its final
// digit, and bytes dropped after an abort or a zero byte, yield nothing unless last.
// An accepted request is written into the queue and its response is then
// registered before it leaves on rsp_; the sustained rate is one request per
// cycle while rsp_stall is low, set by the escape state machine in the back end.
// The queue holds QUEUE_DEPTH classified requests, so the front end keeps
// accepting while a response waits; req_stall rises only when it is full.
// A stalled response holds in the output register while the back end waits.
// Reset is synchronous: it empties the queue, drops any pending response and
// returns the decoder to normal phase with no escape and no abort pending.
module url_percent_decoder #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  upd_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output upd_pkg::rsp_type rsp_payload
);
   import upd_pkg::*;

   cls_type push_item;
   cls_type head_item;
   logic    push;
   logic    pop;
   logic    queue_full;
   logic    queue_not_empty;

   upd_front u_front (
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .queue_full  (queue_full),
      .push        (push),
      .item        (push_item)
   );

   upd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (queue_full),
      .not_empty (queue_not_empty),
      .pop       (pop),
      .head      (head_item)
   );

   upd_back u_back (
      .clock       (clock),
      .reset       (reset),
      .item_valid  (queue_not_empty),
      .item        (head_item),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   // An abort is only ever reported on the response that closes a string.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.aborted |-> rsp_payload.end_of_string)
      else $error("aborted response without end of string");

   // A response without a byte exists only to close a string.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.has_byte |-> rsp_payload.end_of_string)
      else $error("empty response that does not close a string");

   // Without a byte the data field reads as zero, and a decoded zero is never sent.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.has_byte == (rsp_payload.out_byte != 8'h00)))
      else $error("response byte and has_byte disagree");

   // The queue can only be popped when it holds an entry.
   assert property (@(posedge clock) disable iff (reset)
      pop |-> queue_not_empty)
      else $error("queue popped while empty");

endmodule
